// File: sv/flagged_rle_blit_decoder_assert.svh
// Assertion macros used by the decoder's top-level RTL file.
`ifndef FLAGGED_RLE_BLIT_DECODER_ASSERT_SVH
`define FLAGGED_RLE_BLIT_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frbd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FRBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frbd assertion failed");

`endif

// File: sv/frbd_pkg.sv
// Types, constants and helper functions of the flagged run-length blit decoder.
package frbd_pkg;

  localparam int ADDRESS_BITS = 25;
  localparam int RUN_BITS     = 8;

  localparam int COL_W   = 13;
  localparam int PITCH_W = 14;
  localparam int OX_W    = 13;
  localparam int OY_W    = 12;
  localparam int PIX_W   = 25;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 3;

  // Width at which the room left in a row is compared with the remaining run.
  localparam int CMP_W = (COL_W > RUN_BITS) ? COL_W : RUN_BITS;

  localparam logic [COL_W-1:0] WIDTH_MIN  = COL_W'(8);
  localparam logic [COL_W-1:0] WIDTH_MAX  = COL_W'(4096);
  localparam logic [COL_W-1:0] HEIGHT_MIN = COL_W'(1);
  localparam logic [COL_W-1:0] HEIGHT_MAX = COL_W'(4096);

  // A literal token places exactly one pixel.
  localparam logic [RUN_BITS-1:0] LITERAL_LEN = RUN_BITS'(8'h01);

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LINE_PITCH   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_ORIGIN_X     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_ORIGIN_Y     = IDX_W'(4);

  typedef struct packed {
    logic       is_run;
    logic [7:0] color;
    logic [7:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] write_address;
    logic [RUN_BITS-1:0]     span_length;
    logic [7:0]              pixel_value;
    logic                    last_span;
    logic                    image_done;
  } out_item_t;

  // Position of the writer inside the current image.
  typedef struct packed {
    logic [ADDRESS_BITS-1:0] write_pointer;
    logic [COL_W-1:0]        column_count;
    logic [PIX_W-1:0]        pixels_written;
  } cursor_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN
  } state_t;

  function automatic logic [COL_W-1:0] clamp_width(input logic [COL_W-1:0] w);
    logic [COL_W-1:0] r;
    r = w;
    if (w < WIDTH_MIN) r = WIDTH_MIN;
    else if (w > WIDTH_MAX) r = WIDTH_MAX;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_height(input logic [COL_W-1:0] h);
    logic [COL_W-1:0] r;
    r = h;
    if (h < HEIGHT_MIN) r = HEIGHT_MIN;
    else if (h > HEIGHT_MAX) r = HEIGHT_MAX;
    return r;
  endfunction

endpackage

// File: sv/flagged_rle_blit_decoder.sv
// Top level of the flagged run-length blit decoder: sequencer, state and output register.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready  | in_data (in_item_t: flag, color, length)
//  out_    | output    | out_valid / out_ready| out_data (out_item_t: one row span)
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
// A token is accepted in idle, passes the preparation state and yields its spans in the
// run state (1 for a literal, up to 33 for a run, none for a zero-length run); the single
// span unit produces one span per cycle, but a stall on out_ready holds it until the output
// register empties. The preparation cycle loads the origin address through one multiplier
// when a new image starts. Reset (rst_n low, synchronous) restores the default registers
// and closes the image; in_ready is low while reset is held and rises when rst_n rises.
`include "flagged_rle_blit_decoder_assert.svh"

module flagged_rle_blit_decoder import frbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic [COL_W-1:0]   image_width_r;
  logic [COL_W-1:0]   image_height_r;
  logic [PITCH_W-1:0] line_pitch_r;
  logic [OX_W-1:0]    origin_x_r;
  logic [OY_W-1:0]    origin_y_r;

  state_t state_r, state_nxt;
  logic   image_open_r, image_open_nxt;
  logic   out_valid_r, out_valid_nxt;

  cursor_t              cur_r, cur_nxt;
  logic [RUN_BITS-1:0]  rem_r, rem_nxt;
  logic [7:0]           color_r, color_nxt;
  out_item_t            out_data_r, out_data_nxt;
  logic [PIX_W-1:0]     size_r;

  logic [COL_W-1:0]         eff_width;
  logic [2*COL_W-1:0]       size_prod;
  logic [OY_W+PITCH_W-1:0]  origin_prod;
  logic [ADDRESS_BITS-1:0]  start_addr;
  logic                     fire;

  out_item_t            span;
  cursor_t              span_cur;
  logic [RUN_BITS-1:0]  span_rem;

  assign eff_width   = clamp_width(image_width_r);
  assign size_prod   = eff_width * clamp_height(image_height_r);
  assign origin_prod = origin_y_r * line_pitch_r;
  assign start_addr  = ADDRESS_BITS'(origin_prod) + ADDRESS_BITS'(origin_x_r);

  frbd_span_unit u_span (
    .cur_i   (cur_r),
    .rem_i   (rem_r),
    .width_i (eff_width),
    .pitch_i (line_pitch_r),
    .size_i  (size_r),
    .color_i (color_r),
    .span_o  (span),
    .cur_o   (span_cur),
    .rem_o   (span_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= COL_W'(64);
      image_height_r <= COL_W'(64);
      line_pitch_r   <= PITCH_W'(64);
      origin_x_r     <= '0;
      origin_y_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[COL_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[COL_W-1:0];
        REG_LINE_PITCH:   line_pitch_r   <= cfg_data[PITCH_W-1:0];
        REG_ORIGIN_X:     origin_x_r     <= cfg_data[OX_W-1:0];
        REG_ORIGIN_Y:     origin_y_r     <= cfg_data[OY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      image_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cur_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      image_open_r <= image_open_nxt;
      out_valid_r  <= out_valid_nxt;
      cur_r        <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    color_r    <= color_nxt;
    out_data_r <= out_data_nxt;
    size_r     <= PIX_W'(size_prod);
  end

  always_comb begin
    state_nxt      = state_r;
    image_open_nxt = image_open_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    color_nxt      = color_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    fire           = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid) begin
          color_nxt = in_data.color;
          rem_nxt   = in_data.is_run ? in_data.run_length[RUN_BITS-1:0] : LITERAL_LEN;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (rem_r == '0) begin
          // A zero-length run leaves the cursor and the image state as they were.
          state_nxt = ST_IDLE;
        end else begin
          if (!image_open_r) begin
            cur_nxt.write_pointer  = start_addr;
            cur_nxt.column_count   = '0;
            cur_nxt.pixels_written = '0;
            image_open_nxt         = 1'b1;
          end
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        fire = !out_valid_r || out_ready;
        if (fire) begin
          out_data_nxt  = span;
          out_valid_nxt = 1'b1;
          cur_nxt       = span_cur;
          rem_nxt       = span_rem;
          if (span.last_span) begin
            image_open_nxt = !span.image_done;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FRBD_ASSERT_SAME(a_span_nonzero, clk, rst_n, out_valid_r, out_data_r.span_length != '0)
  `FRBD_ASSERT_SAME(a_run_has_work, clk, rst_n, state_r == ST_RUN, rem_r != '0)
  `FRBD_ASSERT_NEXT(a_last_ends_token, clk, rst_n, fire && span.last_span,
                    state_r == ST_IDLE && out_valid_r && out_data_r.last_span)
  `FRBD_ASSERT_NEXT(a_done_closes_image, clk, rst_n,
                    fire && span.last_span && span.image_done, !image_open_r)

endmodule

// File: sv/frbd_span_unit.sv
// Combinational span unit: cuts one row-bounded span off the remaining run each cycle in which the top level takes it.
module frbd_span_unit import frbd_pkg::*; (
  input  cursor_t                 cur_i,
  input  logic [RUN_BITS-1:0]     rem_i,
  input  logic [COL_W-1:0]        width_i,
  input  logic [PITCH_W-1:0]      pitch_i,
  input  logic [PIX_W-1:0]        size_i,
  input  logic [7:0]              color_i,
  output out_item_t               span_o,
  output cursor_t                 cur_o,
  output logic [RUN_BITS-1:0]     rem_o
);

  logic                    wrap;
  logic [ADDRESS_BITS-1:0] wp_a;
  logic [COL_W-1:0]        col_a;
  logic [COL_W-1:0]        room;
  logic [RUN_BITS-1:0]     n;
  logic [PIX_W-1:0]        pix_nxt;

  always_comb begin
    // A column at or past the width skips to the next line before placing pixels.
    wrap  = (cur_i.column_count >= width_i);
    wp_a  = wrap ? (cur_i.write_pointer + ADDRESS_BITS'(pitch_i) - ADDRESS_BITS'(width_i))
                 : cur_i.write_pointer;
    col_a = wrap ? '0 : cur_i.column_count;
    room  = width_i - col_a;
    n     = (CMP_W'(room) > CMP_W'(rem_i)) ? rem_i : RUN_BITS'(room);

    pix_nxt = cur_i.pixels_written + PIX_W'(n);
    rem_o   = rem_i - n;

    cur_o.write_pointer  = wp_a + ADDRESS_BITS'(n);
    cur_o.column_count   = col_a + COL_W'(n);
    cur_o.pixels_written = pix_nxt;

    span_o.write_address = wp_a;
    span_o.span_length   = n;
    span_o.pixel_value   = color_i;
    span_o.last_span     = (rem_o == '0);
    span_o.image_done    = (pix_nxt >= size_i);
  end

endmodule

// File: tb/flagged_rle_blit_decoder_test.sv
// Self-checking testbench for the flagged run-length blit decoder, with span prediction.
`timescale 1ns / 100ps

module flagged_rle_blit_decoder_test import frbd_pkg::*; ;

  localparam logic [IDX_W-1:0] REG_SPARE = IDX_W'(5);
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {
    RX_STREAM,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  flagged_rle_blit_decoder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Mirror of the geometry registers as the block holds them.
  logic [COL_W-1:0] geo_width = COL_W'(64);
  logic [COL_W-1:0] geo_height = COL_W'(64);
  logic [PITCH_W-1:0] geo_pitch = PITCH_W'(64);
  logic [OX_W-1:0] geo_ox = '0;
  logic [OY_W-1:0] geo_oy = '0;

  // Predicted writer position within the image.
  logic [ADDRESS_BITS-1:0] blit_ptr = '0;
  logic [COL_W-1:0] blit_col = '0;
  logic [PIX_W-1:0] blit_pixels = '0;
  logic image_open = 1'b0;

  in_item_t token_queue[$];
  out_item_t expected_spans[$];
  int tokens_queued = 0;
  int tokens_taken = 0;
  int err_count = 0;

  bit item_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  bit hold_req = 1'b0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_STREAM;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_spans(input in_item_t tok);
    logic [COL_W-1:0] width_eff;
    logic [COL_W-1:0] height_eff;
    logic [PIX_W-1:0] image_size;
    logic [RUN_BITS-1:0] left;
    logic [COL_W-1:0] n;
    out_item_t span;
    width_eff = geo_width;
    if (geo_width < 8) width_eff = COL_W'(8);
    else if (geo_width > 4096) width_eff = COL_W'(4096);
    height_eff = geo_height;
    if (geo_height < 1) height_eff = COL_W'(1);
    else if (geo_height > 4096) height_eff = COL_W'(4096);
    image_size = PIX_W'(width_eff) * PIX_W'(height_eff);
    left = tok.is_run ? tok.run_length : LITERAL_LEN;
    // A zero-length run leaves everything alone, even a closed image.
    if (left != 0) begin
      if (!image_open) begin
        blit_ptr = ADDRESS_BITS'(geo_oy) * ADDRESS_BITS'(geo_pitch) + ADDRESS_BITS'(geo_ox);
        blit_col = '0;
        blit_pixels = '0;
        image_open = 1'b1;
      end
      while (left != 0) begin
        if (blit_col >= width_eff) begin
          blit_ptr = blit_ptr + ADDRESS_BITS'(geo_pitch) - ADDRESS_BITS'(width_eff);
          blit_col = '0;
        end
        n = width_eff - blit_col;
        if (n > COL_W'(left)) n = COL_W'(left);
        left = left - n[RUN_BITS-1:0];
        blit_pixels = blit_pixels + PIX_W'(n);
        span.write_address = blit_ptr;
        span.span_length = n[RUN_BITS-1:0];
        span.pixel_value = tok.color;
        span.last_span = (left == 0);
        span.image_done = (blit_pixels >= image_size);
        expected_spans.push_back(span);
        blit_ptr = blit_ptr + ADDRESS_BITS'(n);
        blit_col = blit_col + n;
      end
      if (blit_pixels >= image_size) image_open = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Input acceptance feeds the predictor; output transfers are checked in order.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_spans(in_data);
        item_taken = 1'b1;
        tokens_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_spans.size() == 0) begin
          err_count++;
          $display("%0t: unexpected span, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_spans.pop_front();
          if (out_data.write_address !== want.write_address)
            report_mismatch("write_address", want.write_address, out_data.write_address);
          if (out_data.span_length !== want.span_length)
            report_mismatch("span_length", want.span_length, out_data.span_length);
          if (out_data.pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", want.pixel_value, out_data.pixel_value);
          if (out_data.last_span !== want.last_span)
            report_mismatch("last_span", want.last_span, out_data.last_span);
          if (out_data.image_done !== want.image_done)
            report_mismatch("image_done", want.image_done, out_data.image_done);
        end
      end
    end
  end

  // Token sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (token_queue.size() != 0) begin
        in_data <= token_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Span receiver: switches among stall patterns, plus one long hold on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STREAM: out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_IMAGE_WIDTH: geo_width = val[COL_W-1:0];
      REG_IMAGE_HEIGHT: geo_height = val[COL_W-1:0];
      REG_LINE_PITCH: geo_pitch = val[PITCH_W-1:0];
      REG_ORIGIN_X: geo_ox = val[OX_W-1:0];
      REG_ORIGIN_Y: geo_oy = val[OY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] ox,
                              input logic [CFG_W-1:0] oy);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LINE_PITCH, p);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
  endtask

  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (tokens_taken != tokens_queued || expected_spans.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  task automatic queue_token(input logic is_run, input logic [7:0] color,
                             input logic [7:0] run_length);
    in_item_t tok;
    tok.is_run = is_run;
    tok.color = color;
    tok.run_length = run_length;
    token_queue.push_back(tok);
    tokens_queued++;
  endtask

  // Mostly short runs and literals, with empty, long and full-length runs mixed in.
  task automatic queue_random(input int count);
    int placed;
    int pick;
    logic is_run;
    logic [7:0] len;
    placed = 0;
    while (placed < count) begin
      is_run = ($urandom_range(0, 99) < 55);
      pick = $urandom_range(0, 19);
      if (!is_run) len = 8'($urandom_range(0, 255));
      else if (pick < 2) len = 8'd0;
      else if (pick < 14) len = 8'($urandom_range(1, 16));
      else if (pick < 19) len = 8'($urandom_range(17, 255));
      else len = 8'hFF;
      queue_token(is_run, 8'($urandom_range(0, 255)), len);
      if (!is_run || len != 0) placed++;
    end
  endtask

  initial begin
    int w;
    int ox;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: literals with ignored lengths, an empty run, runs across rows.
    queue_token(1'b0, 8'h00, 8'hFF);
    queue_token(1'b0, 8'hFF, 8'h00);
    queue_token(1'b1, 8'hAA, 8'h00);
    queue_token(1'b1, 8'h55, 8'h01);
    queue_token(1'b1, 8'hFF, 8'hFF);
    queue_token(1'b1, 8'h00, 8'hAA);
    queue_token(1'b0, 8'hAA, 8'h55);
    queue_token(1'b1, 8'h55, 8'h55);
    queue_token(1'b1, 8'h0F, 8'h40);
    wait_idle(SETTLE_CYCLES);

    // Clamped width and height, a pitch below the width, origin at its maximum.
    // The first literal closes the image left open above.
    write_reg(REG_SPARE, 14'h3FFF);
    set_geometry(14'd3, 14'd0, 14'd5, 14'd8191, 14'd4095);
    queue_token(1'b0, 8'h01, 8'h00);
    queue_token(1'b0, 8'h02, 8'h00);
    queue_token(1'b0, 8'h03, 8'h00);
    queue_token(1'b1, 8'h96, 8'hFF);
    queue_token(1'b1, 8'h77, 8'h00);
    queue_token(1'b0, 8'h80, 8'h00);
    wait_idle(SETTLE_CYCLES);

    // Narrowing the width mid-row forces the line skip before the next pixel.
    set_geometry(14'd16, 14'd4, 14'd20, 14'd2, 14'd3);
    queue_token(1'b1, 8'h3C, 8'd12);
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_IMAGE_WIDTH, 14'd8);
    queue_token(1'b0, 8'hC3, 8'h00);
    queue_token(1'b1, 8'h11, 8'd20);
    wait_idle(SETTLE_CYCLES);

    set_geometry(14'd8, 14'd2, 14'd8, 14'd0, 14'd0);
    queue_random(60);
    wait_idle(SETTLE_CYCLES);

    // Long receiver hold while tokens keep coming, so the input backs up.
    set_geometry(14'd13, 14'd3, 14'd40, 14'd5, 14'd7);
    hold_req = 1'b1;
    queue_random(50);
    wait_idle(SETTLE_CYCLES);

    set_geometry(14'h3FFF, 14'd8191, 14'd16383, 14'd8191, 14'd4095);
    queue_random(40);
    wait_idle(SETTLE_CYCLES);

    set_geometry(14'd4096, 14'd4096, 14'd8, 14'd100, 14'd4095);
    queue_random(30);
    wait_idle(SETTLE_CYCLES);

    for (int phase = 0; phase < 4; phase++) begin
      w = (phase == 3) ? $urandom_range(0, 7) : $urandom_range(8, 40);
      ox = $urandom_range(0, 50);
      set_geometry(CFG_W'(w), CFG_W'($urandom_range(1, 6)),
                   CFG_W'((w < 8 ? 8 : w) + ox + int'($urandom_range(0, 30))),
                   CFG_W'(ox), CFG_W'($urandom_range(0, 4095)));
      queue_random(35);
      wait_idle(SETTLE_CYCLES);
    end

    wait_idle(4 * SETTLE_CYCLES);
    if (err_count == 0)
      $display("flagged_rle_blit_decoder_test: clean");
    else
      $display("flagged_rle_blit_decoder_test: errors");
    $finish;
  end

  initial begin
    #5000000;
    $display("flagged_rle_blit_decoder_test: errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/frbd_pkg.sv
sv/frbd_span_unit.sv
sv/flagged_rle_blit_decoder.sv
tb/flagged_rle_blit_decoder_test.sv
